// ----- src/kfilt_pkg.sv -----
// Shared types and constants of the 3x3 kernel image filter.
// Used by every module of the block; depends on nothing.
package kfilt_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;

  localparam int PIX_W     = 8;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 12;
  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;
  localparam int SUM_W     = 13;
  localparam int OUT_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [2:0]         FILTER_RESET = 3'd1;
  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd256;
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd256;

  // box average: floor(S * 11111 / 100000), estimated then corrected by one step
  localparam int BOX_NUM    = 11111;
  localparam int BOX_DEN    = 100000;
  localparam int BOX_RECIP  = 7281;
  localparam int BOX_SHIFT  = 16;
  // exact floor(x / 3) for x up to 765
  localparam int DIV3_RECIP = 683;
  localparam int DIV3_SHIFT = 11;

  typedef enum logic [2:0] {
    FILT_BOX       = 3'd0,
    FILT_GAUSS     = 3'd1,
    FILT_PREWITT_X = 3'd2,
    FILT_PREWITT_Y = 3'd3,
    FILT_SOBEL_X   = 3'd4,
    FILT_SOBEL_Y   = 3'd5,
    FILT_LAPLACE   = 3'd6,
    FILT_SHARPEN   = 3'd7
  } filt_sel_e;

  // entry i is tap i of the window, row-major, top-left first
  typedef logic [8:0][PIX_W-1:0] window_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } meta_t;

endpackage

// ----- src/kfilt_linebuf.sv -----
// Line memory and 3x3 window of the kernel image filter.
// One read-modify-write of a {mid, top} column entry per pixel; uses kfilt_pkg.
module kfilt_linebuf #(
  parameter int MAX_WIDTH = kfilt_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          push_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  addr_i,
  input  logic [kfilt_pkg::PIX_W-1:0]   pixel_i,
  output kfilt_pkg::window_t            window_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PW = kfilt_pkg::PIX_W;

  // entry: [2*PW-1:PW] row above current, [PW-1:0] two rows above
  logic [2*PW-1:0] mem [MAX_WIDTH];

  logic [2*PW-1:0]    rd_q;
  logic               s1_valid_q;
  logic [AW-1:0]      s1_addr_q;
  logic [PW-1:0]      s1_pixel_q;
  logic               fwd_q;
  logic [2*PW-1:0]    fwd_data_q;
  kfilt_pkg::window_t window_q;
  kfilt_pkg::window_t window_d;

  logic [2*PW-1:0] entry;
  logic [2*PW-1:0] wr_data;
  logic            wr_en;

  assign entry   = fwd_q ? fwd_data_q : rd_q;
  assign wr_data = {s1_pixel_q, entry[2*PW-1:PW]};
  assign wr_en   = adv_i && s1_valid_q;

  always_ff @(posedge clk_i) begin
    if (adv_i && push_i) begin
      rd_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_addr_q] <= wr_data;
    end
  end

  // forward the entry written this cycle when the next pixel reads the same column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= push_i;
      fwd_q      <= s1_valid_q && (addr_i == s1_addr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && push_i) begin
      s1_addr_q  <= addr_i;
      s1_pixel_q <= pixel_i;
      fwd_data_q <= wr_data;
    end
  end

  always_comb begin
    window_d = window_q;
    for (int k = 0; k < 3; k++) begin
      window_d[3*k]   = window_q[3*k+1];
      window_d[3*k+1] = window_q[3*k+2];
    end
    window_d[2] = entry[PW-1:0];
    window_d[5] = entry[2*PW-1:PW];
    window_d[8] = s1_pixel_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (wr_en) begin
      window_q <= window_d;
    end
  end

  assign window_o = window_q;

endmodule

// ----- src/kfilt_calc.sv -----
// Kernel arithmetic of the 3x3 image filter: weighted sum, scaling, output register.
// Three register stages behind the window; uses kfilt_pkg.
module kfilt_calc (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  kfilt_pkg::meta_t            meta_i,
  input  kfilt_pkg::window_t          window_i,
  input  kfilt_pkg::filt_sel_e        sel_i,
  output logic                        out_valid_o,
  output logic [kfilt_pkg::PIX_W-1:0] out_pixel_o,
  output kfilt_pkg::meta_t            out_meta_o
);

  localparam int SW = kfilt_pkg::SUM_W;
  localparam int PW = kfilt_pkg::PIX_W;
  localparam int MW = 25;

  logic signed [SW-1:0] p [9];
  logic signed [SW-1:0] nb;
  logic signed [SW-1:0] sum_d;

  logic                 a_valid_q;
  logic signed [SW-1:0] a_sum_q;
  kfilt_pkg::filt_sel_e a_sel_q;
  kfilt_pkg::meta_t     a_meta_q;

  logic [SW-2:0] mag;
  logic [MW-1:0] box_prod;
  logic [MW-1:0] box_est;
  logic [19:0]   div3;
  logic [PW-1:0] val_d;

  logic             b_valid_q;
  logic             b_box_q;
  logic [MW-1:0]    b_prod_q;
  logic [PW-1:0]    b_q0_q;
  logic [PW-1:0]    b_val_q;
  kfilt_pkg::meta_t b_meta_q;

  logic [MW-1:0] box_back;
  logic [MW-1:0] box_rem;
  logic [PW-1:0] pix_d;

  logic             o_valid_q;
  logic [PW-1:0]    o_pixel_q;
  kfilt_pkg::meta_t o_meta_q;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i] = $signed({{(SW-PW){1'b0}}, window_i[i]});
    end
    nb = p[0] + p[1] + p[2] + p[3] + p[5] + p[6] + p[7] + p[8];
    case (sel_i)
      kfilt_pkg::FILT_BOX:       sum_d = nb + p[4];
      kfilt_pkg::FILT_GAUSS:     sum_d = p[0] + (p[1] <<< 1) + p[2] + (p[3] <<< 1)
                                       + (p[4] <<< 2) + (p[5] <<< 1) + p[6]
                                       + (p[7] <<< 1) + p[8];
      kfilt_pkg::FILT_PREWITT_X: sum_d = (p[2] + p[5] + p[8]) - (p[0] + p[3] + p[6]);
      kfilt_pkg::FILT_PREWITT_Y: sum_d = (p[6] + p[7] + p[8]) - (p[0] + p[1] + p[2]);
      kfilt_pkg::FILT_SOBEL_X:   sum_d = (p[2] + (p[5] <<< 1) + p[8])
                                       - (p[0] + (p[3] <<< 1) + p[6]);
      kfilt_pkg::FILT_SOBEL_Y:   sum_d = (p[6] + (p[7] <<< 1) + p[8])
                                       - (p[0] + (p[1] <<< 1) + p[2]);
      kfilt_pkg::FILT_LAPLACE:   sum_d = (p[4] <<< 3) - nb;
      kfilt_pkg::FILT_SHARPEN:   sum_d = (p[4] <<< 3) + p[4] - nb;
      default:                   sum_d = '0;
    endcase
  end

  always_comb begin
    mag      = a_sum_q[SW-1] ? (SW-1)'(-a_sum_q) : a_sum_q[SW-2:0];
    box_prod = MW'(a_sum_q[SW-2:0]) * MW'(kfilt_pkg::BOX_NUM);
    box_est  = MW'(a_sum_q[SW-2:0]) * MW'(kfilt_pkg::BOX_RECIP);
    div3     = 20'(mag[9:0]) * 20'(kfilt_pkg::DIV3_RECIP);
    case (a_sel_q)
      kfilt_pkg::FILT_GAUSS:     val_d = a_sum_q[11:4];
      kfilt_pkg::FILT_PREWITT_X: val_d = div3[kfilt_pkg::DIV3_SHIFT +: PW];
      kfilt_pkg::FILT_PREWITT_Y: val_d = div3[kfilt_pkg::DIV3_SHIFT +: PW];
      kfilt_pkg::FILT_SOBEL_X:   val_d = mag[9:2];
      kfilt_pkg::FILT_SOBEL_Y:   val_d = mag[9:2];
      kfilt_pkg::FILT_LAPLACE:   val_d = mag[10:3];
      kfilt_pkg::FILT_SHARPEN: begin
        if (a_sum_q[SW-1]) begin
          val_d = '0;
        end else if (a_sum_q[SW-2:PW] != '0) begin
          val_d = '1;
        end else begin
          val_d = a_sum_q[PW-1:0];
        end
      end
      default:                   val_d = '0;
    endcase
  end

  always_comb begin
    box_back = MW'(b_q0_q) * MW'(kfilt_pkg::BOX_DEN);
    box_rem  = b_prod_q - box_back;
    if (b_box_q) begin
      pix_d = (box_rem >= MW'(kfilt_pkg::BOX_DEN)) ? b_q0_q + PW'(1) : b_q0_q;
    end else begin
      pix_d = b_val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      o_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_sum_q   <= sum_d;
      a_sel_q   <= sel_i;
      a_meta_q  <= meta_i;
      b_box_q   <= (a_sel_q == kfilt_pkg::FILT_BOX);
      b_prod_q  <= box_prod;
      b_q0_q    <= box_est[kfilt_pkg::BOX_SHIFT +: PW];
      b_val_q   <= val_d;
      b_meta_q  <= a_meta_q;
      o_pixel_q <= pix_d;
      o_meta_q  <= b_meta_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_pixel_o = o_pixel_q;
  assign out_meta_o  = o_meta_q;

endmodule

// ----- src/kernel3x3_image_filter.sv -----
// Top level of the streaming 3x3 kernel image filter.
// Instantiates kfilt_linebuf and kfilt_calc; uses kfilt_pkg.
//
// Takes one 8-bit pixel per clock in raster order and returns one filtered pixel per
// interior window centre; border positions give no result. The sustained rate is one
// pixel per cycle while the output accepts, set by the single read-modify-write of the
// line memory per pixel (one read port, one write port, with forwarding when two
// pixels in a row hit the same column). A result passes through memory read, window
// update, weighted sum, scaling and output register. The whole pipeline holds while a
// result waits at the output. The line memory needs no clearing after reset.
// Configuration is to be written only while no pixel is in flight; the block does not enforce it.
module kernel3x3_image_filter #(
  parameter int MAX_WIDTH = kfilt_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kfilt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [kfilt_pkg::CFG_DAT_W-1:0]   cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] pixel_in
  input  logic [0:0]                        s_axis_tuser,  // [0] frame_start
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] pixel_out, [17:8] center_col, [29:18] center_row, [31:30] zero
  output logic [kfilt_pkg::OUT_DAT_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast   // frame_last
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > kfilt_pkg::IMG_W_W) ? WW : kfilt_pkg::IMG_W_W;
  localparam int CXW  = (AW > kfilt_pkg::COL_W) ? AW : kfilt_pkg::COL_W;
  localparam int RW   = kfilt_pkg::ROW_W;
  localparam int HW   = kfilt_pkg::IMG_H_W;

  logic [2:0]                  filter_q;
  logic [kfilt_pkg::IMG_W_W-1:0] width_q;
  logic [HW-1:0]               height_q;

  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic          adv;
  logic          accept;
  logic [WW-1:0] wc;
  logic [HW-1:0] hc;
  logic [AW-1:0] c0, c;
  logic [RW-1:0] r0;
  logic [HW-1:0] r1;
  logic [RW-1:0] r;
  logic [WW-1:0] cn;
  logic [HW-1:0] rn;
  logic [CXW-1:0] ccol;
  logic          emit;
  kfilt_pkg::meta_t meta_d;

  logic             s1_emit_q;
  kfilt_pkg::meta_t s1_meta_q;
  logic             s2_valid_q;
  kfilt_pkg::meta_t s2_meta_q;

  kfilt_pkg::window_t          window;
  logic                        out_valid;
  logic [kfilt_pkg::PIX_W-1:0] out_pixel;
  kfilt_pkg::meta_t            out_meta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= kfilt_pkg::FILTER_RESET;
      width_q  <= kfilt_pkg::WIDTH_RESET;
      height_q <= kfilt_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kfilt_pkg::CFG_FILTER: filter_q <= cfg_wdata_i[2:0];
        kfilt_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i[kfilt_pkg::IMG_W_W-1:0];
        kfilt_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i[HW-1:0];
        default: ;
      endcase
    end
  end

  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  always_comb begin
    if (width_q < kfilt_pkg::IMG_W_W'(3)) begin
      wc = WW'(3);
    end else if (CMPW'(width_q) > CMPW'(MAX_WIDTH)) begin
      wc = WW'(MAX_WIDTH);
    end else begin
      wc = WW'(width_q);
    end
    if (height_q < HW'(3)) begin
      hc = HW'(3);
    end else if (height_q > HW'(kfilt_pkg::MAX_HEIGHT)) begin
      hc = HW'(kfilt_pkg::MAX_HEIGHT);
    end else begin
      hc = height_q;
    end
  end

  // locate the pixel, wrapping past a shrunk width or height
  always_comb begin
    c0 = s_axis_tuser[0] ? '0 : col_q;
    r0 = s_axis_tuser[0] ? '0 : row_q;
    if (WW'(c0) >= wc) begin
      c  = '0;
      r1 = HW'(r0) + HW'(1);
    end else begin
      c  = c0;
      r1 = HW'(r0);
    end
    r = (r1 >= hc) ? '0 : r1[RW-1:0];

    cn = WW'(c) + WW'(1);
    rn = HW'(r) + HW'(1);
    if (cn >= wc) begin
      col_d = '0;
      row_d = (rn >= hc) ? '0 : rn[RW-1:0];
    end else begin
      col_d = cn[AW-1:0];
      row_d = r;
    end

    emit        = (r >= RW'(2)) && (c >= AW'(2));
    ccol        = CXW'(c) - CXW'(1);
    meta_d.col  = ccol[kfilt_pkg::COL_W-1:0];
    meta_d.row  = r - RW'(1);
    meta_d.last = (HW'(r) == hc - HW'(1)) && (WW'(c) == wc - WW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_emit_q  <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_emit_q  <= accept && emit;
      s2_valid_q <= s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_meta_q <= meta_d;
      s2_meta_q <= s1_meta_q;
    end
  end

  kfilt_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .push_i   (accept),
    .addr_i   (c),
    .pixel_i  (s_axis_tdata),
    .window_o (window)
  );

  kfilt_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (s2_valid_q),
    .meta_i      (s2_meta_q),
    .window_i    (window),
    .sel_i       (kfilt_pkg::filt_sel_e'(filter_q)),
    .out_valid_o (out_valid),
    .out_pixel_o (out_pixel),
    .out_meta_o  (out_meta)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_meta.row, out_meta.col, out_pixel};
  assign m_axis_tlast  = out_meta.last;

endmodule

// ----- src/kfilt_checker.sv -----
// Port-level checks for the 3x3 kernel image filter.
// Bound to kernel3x3_image_filter; uses kfilt_pkg.
module kfilt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [kfilt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [kfilt_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [7:0]                      s_axis_tdata,
  input logic [0:0]                      s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [kfilt_pkg::OUT_DAT_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[17:8] != 10'd0) && (m_axis_tdata[29:18] != 12'd0)
      && (m_axis_tdata[31:30] == 2'b00))
    else $error("result centre on border or padding set");

endmodule

bind kernel3x3_image_filter kfilt_checker u_kfilt_checker (.*);
